// ===== rtl/radial_brighten_vignette_core_assert.svh =====
// Assertion helpers for the core RTL file.
`ifndef RADIAL_BRIGHTEN_VIGNETTE_CORE_ASSERT_SVH
`define RADIAL_BRIGHTEN_VIGNETTE_CORE_ASSERT_SVH

// Same-cycle implication, off while reset is held.
`define RBV_ASSERT_IMPLY(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
        else $error("implication check failed");

// Next-cycle implication, off while reset is held.
`define RBV_ASSERT_NEXT(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/rbv_pkg.sv =====
`default_nettype none

package rbv_pkg;

    // Register map
    localparam int IDX_W = 3;
    localparam int CFG_W = 16;

    typedef enum logic [IDX_W-1:0] {
        REG_CENTER_X   = 3'd0,
        REG_CENTER_Y   = 3'd1,
        REG_LEVEL_Q16  = 3'd2,
        REG_IMAGE_ROWS = 3'd3,
        REG_IMAGE_COLS = 3'd4
    } cfg_reg_t;

    // Field widths
    localparam int COORD_W = 12;
    localparam int CENTER_W = 14;
    localparam int LEVEL_W = 16;
    localparam int DIMREG_W = 13;
    localparam int CHAN_W = 8;

    // Arithmetic widths
    localparam int DX_W = CENTER_W + 1;
    localparam int SQ_W = 28;
    localparam int RA_W = SQ_W + 1;
    localparam int FRAC_W = 16;
    localparam int X_W = RA_W + FRAC_W;
    localparam int OLV_W = FRAC_W + 1;
    localparam int QUO_W = 8;

    // Constants
    localparam int MAX_DIM_DEF = 4096;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX_Q16 = 16'd58982;
    localparam logic [OLV_W-1:0] ONE_Q16 = 17'd65536;
    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

    // Width of the Q.16 radius bound for a given dimension limit
    function automatic int bound_width(input int max_dim);
        int dim_w;
        dim_w = $clog2(max_dim + 1);
        return (2 * dim_w - 2) + 1 + OLV_W;
    endfunction

    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } pix_t;

    // zero: no boost; full: boost saturates at 255
    typedef struct packed {
        logic zero;
        logic full;
    } flag_t;

endpackage

`default_nettype wire

// ===== rtl/rbv_bound.sv =====
`default_nettype none

module rbv_bound #(
    parameter int MAX_DIM = rbv_pkg::MAX_DIM_DEF,
    parameter int BOUND_W = rbv_pkg::bound_width(MAX_DIM)
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_we,
    input  wire logic [rbv_pkg::IDX_W-1:0]         cfg_index,
    input  wire logic [rbv_pkg::CFG_W-1:0]         cfg_data,
    output logic      [rbv_pkg::CENTER_W-1:0]      center_x,
    output logic      [rbv_pkg::CENTER_W-1:0]      center_y,
    output logic      [BOUND_W-1:0]                bound
);

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int HALF_W = 2 * DIM_W - 2;
    localparam int BASE_W = HALF_W + 1;
    localparam int PROD_W = 2 * DIM_W;
    localparam int CMP_W = rbv_pkg::DIMREG_W + 1;

    logic [rbv_pkg::CENTER_W-1:0] cx_reg;
    logic [rbv_pkg::CENTER_W-1:0] cy_reg;
    logic [rbv_pkg::LEVEL_W-1:0]  level_reg;
    logic [rbv_pkg::DIMREG_W-1:0] rows_reg;
    logic [rbv_pkg::DIMREG_W-1:0] cols_reg;

    logic [HALF_W-1:0]            hr_reg;
    logic [HALF_W-1:0]            hc_reg;
    logic [rbv_pkg::OLV_W-1:0]    olv_reg;
    logic [BASE_W-1:0]            base_reg;
    logic [rbv_pkg::OLV_W-1:0]    olv2_reg;
    logic [BOUND_W-1:0]           bound_reg;

    logic [HALF_W-1:0]            hr_next;
    logic [HALF_W-1:0]            hc_next;
    logic [rbv_pkg::OLV_W-1:0]    olv_next;
    logic [rbv_pkg::LEVEL_W-1:0]  lv_clamped;

    // (n/2)*n/2 with n limited to MAX_DIM
    function automatic logic [HALF_W-1:0] half_term(input logic [rbv_pkg::DIMREG_W-1:0] n);
        logic [DIM_W-1:0]  n_eff;
        logic [PROD_W-1:0] prod;
        if ({1'b0, n} > CMP_W'(MAX_DIM)) begin
            n_eff = DIM_W'(MAX_DIM);
        end else begin
            n_eff = DIM_W'(n);
        end
        prod = PROD_W'(n_eff >> 1) * PROD_W'(n_eff);
        return prod[HALF_W:1];
    endfunction

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cx_reg    <= '0;
            cy_reg    <= '0;
            level_reg <= '0;
            rows_reg  <= rbv_pkg::DIMREG_W'(1);
            cols_reg  <= rbv_pkg::DIMREG_W'(1);
        end else if (cfg_we) begin
            unique case (rbv_pkg::cfg_reg_t'(cfg_index))
                rbv_pkg::REG_CENTER_X:   cx_reg    <= cfg_data[rbv_pkg::CENTER_W-1:0];
                rbv_pkg::REG_CENTER_Y:   cy_reg    <= cfg_data[rbv_pkg::CENTER_W-1:0];
                rbv_pkg::REG_LEVEL_Q16:  level_reg <= cfg_data[rbv_pkg::LEVEL_W-1:0];
                rbv_pkg::REG_IMAGE_ROWS: rows_reg  <= cfg_data[rbv_pkg::DIMREG_W-1:0];
                rbv_pkg::REG_IMAGE_COLS: cols_reg  <= cfg_data[rbv_pkg::DIMREG_W-1:0];
                default: ;
            endcase
        end
    end

    // Half terms and clamped level complement
    always_comb begin
        hr_next = half_term(rows_reg);
        hc_next = half_term(cols_reg);
        lv_clamped = (level_reg > rbv_pkg::LEVEL_MAX_Q16) ? rbv_pkg::LEVEL_MAX_Q16 : level_reg;
        olv_next = rbv_pkg::ONE_Q16 - {1'b0, lv_clamped};
    end

    // Register the half terms and level complement, then their sum, then the bound
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hr_reg    <= '0;
            hc_reg    <= '0;
            olv_reg   <= rbv_pkg::ONE_Q16;
            base_reg  <= '0;
            olv2_reg  <= rbv_pkg::ONE_Q16;
            bound_reg <= '0;
        end else begin
            hr_reg    <= hr_next;
            hc_reg    <= hc_next;
            olv_reg   <= olv_next;
            base_reg  <= BASE_W'(hr_reg) + BASE_W'(hc_reg);
            olv2_reg  <= olv_reg;
            bound_reg <= BOUND_W'(olv2_reg) * BOUND_W'(base_reg);
        end
    end

    assign center_x = cx_reg;
    assign center_y = cy_reg;
    assign bound = bound_reg;

endmodule

`default_nettype wire

// ===== rtl/rbv_div_step.sv =====
`default_nettype none

module rbv_div_step #(
    parameter int BOUND_W = rbv_pkg::bound_width(rbv_pkg::MAX_DIM_DEF),
    parameter int K = 0
) (
    input  wire logic                                  aclk,
    input  wire logic                                  load,
    input  wire logic [BOUND_W+rbv_pkg::QUO_W-1:0]     rem_in,
    input  wire logic [rbv_pkg::QUO_W-1:0]             quo_in,
    input  wire rbv_pkg::flag_t                        flag_in,
    input  wire rbv_pkg::pix_t                         pix_in,
    input  wire logic [BOUND_W-1:0]                    bound,
    output logic      [BOUND_W+rbv_pkg::QUO_W-1:0]     rem_out,
    output logic      [rbv_pkg::QUO_W-1:0]             quo_out,
    output rbv_pkg::flag_t                             flag_out,
    output rbv_pkg::pix_t                              pix_out
);

    localparam int DIV_W = BOUND_W + rbv_pkg::QUO_W;

    logic [DIV_W-1:0]          rem_reg;
    logic [rbv_pkg::QUO_W-1:0] quo_reg;
    rbv_pkg::flag_t            flag_reg;
    rbv_pkg::pix_t             pix_reg;

    logic [DIV_W-1:0]          rem_next;
    logic [rbv_pkg::QUO_W-1:0] quo_next;
    logic [DIV_W-1:0]          sub_val;
    logic                      fits;

    // One restoring step: try bound << K against the remainder
    always_comb begin
        sub_val = DIV_W'(bound) << K;
        fits = (rem_in >= sub_val);
        rem_next = fits ? (rem_in - sub_val) : rem_in;
        quo_next = quo_in;
        quo_next[K] = fits;
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            flag_reg <= flag_in;
            pix_reg  <= pix_in;
        end
    end

    assign rem_out = rem_reg;
    assign quo_out = quo_reg;
    assign flag_out = flag_reg;
    assign pix_out = pix_reg;

endmodule

`default_nettype wire

// ===== rtl/radial_brighten_vignette_core.sv =====
// Radial brighten core: adds a feathered white edge to a BGR pixel stream.
// s_ channel: one pixel per transfer with its row and column; m_ channel: the
// brightened pixel, one result per input, in input order.
// Throughput is one pixel per clock while m_tready does not stall the output.
// The pipeline runs from the input transfer to m_tvalid through distance,
// squares, bound compare, numerator, an 8-stage restoring divider for the
// boost, and the saturating add in the output register.
// Configuration goes through cfg_we / cfg_index / cfg_data. The user must write
// it only while the stream is idle (not enforced); the bound then settles.
// Reset (aresetn low, synchronous) empties the pipeline and loads the register
// defaults: center 0, level 0, rows 1, cols 1, bound 0.
// Each stage has its own valid bit and advances when the next one is free, so
// a stall on m_tready fills the empty stages first and only then drops
// s_tready; nothing is lost or repeated.
`default_nettype none

module radial_brighten_vignette_core #(
    parameter int MAX_DIM = rbv_pkg::MAX_DIM_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // Configuration
    input  wire logic                          cfg_we,
    input  wire logic [rbv_pkg::IDX_W-1:0]     cfg_index,
    input  wire logic [rbv_pkg::CFG_W-1:0]     cfg_data,
    // Pixel input
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // pixel_row[11:0], pixel_col[23:12], blue_in[31:24], green_in[39:32], red_in[47:40]
    input  wire logic [47:0]                   s_tdata,
    // Pixel output
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // blue_out[7:0], green_out[15:8], red_out[23:16]
    output logic      [23:0]                   m_tdata
);

    `include "radial_brighten_vignette_core_assert.svh"

    localparam int BOUND_W = rbv_pkg::bound_width(MAX_DIM);
    localparam int DIV_W = BOUND_W + rbv_pkg::QUO_W;
    localparam int CW = (BOUND_W + 1 > rbv_pkg::X_W) ? BOUND_W + 1 : rbv_pkg::X_W;
    localparam int NST = 13;
    localparam int DIV_FIRST = 4;
    localparam int LAST = NST - 1;

    logic [rbv_pkg::CENTER_W-1:0] center_x;
    logic [rbv_pkg::CENTER_W-1:0] center_y;
    logic [BOUND_W-1:0]           bound;

    logic [NST-1:0] v_reg;
    logic [NST-1:0] v_next;
    logic [NST-1:0] en;

    // Input fields
    logic [rbv_pkg::COORD_W-1:0] pixel_row;
    logic [rbv_pkg::COORD_W-1:0] pixel_col;
    rbv_pkg::pix_t               pix_in;

    // Stage 0: offsets
    logic signed [rbv_pkg::DX_W-1:0] dx_reg;
    logic signed [rbv_pkg::DX_W-1:0] dy_reg;
    logic signed [rbv_pkg::DX_W-1:0] dx_next;
    logic signed [rbv_pkg::DX_W-1:0] dy_next;
    rbv_pkg::pix_t                   pix0_reg;

    // Stage 1: squares
    logic signed [2*rbv_pkg::DX_W-1:0] sqx_full;
    logic signed [2*rbv_pkg::DX_W-1:0] sqy_full;
    logic [rbv_pkg::SQ_W-1:0]          sqx_reg;
    logic [rbv_pkg::SQ_W-1:0]          sqy_reg;
    rbv_pkg::pix_t                     pix1_reg;

    // Stage 2: compare against bound
    logic [rbv_pkg::RA_W-1:0] ra;
    logic [CW-1:0]            x_val;
    logic [CW-1:0]            b_ext;
    logic [CW-1:0]            x_diff;
    logic [BOUND_W-1:0]       d_reg;
    rbv_pkg::flag_t           flg2_reg;
    rbv_pkg::flag_t           flg2_next;
    rbv_pkg::pix_t            pix2_reg;

    // Stage 3: numerator 255 * d
    logic [DIV_W-1:0]         num_reg;
    rbv_pkg::flag_t           flg3_reg;
    rbv_pkg::pix_t            pix3_reg;

    // Divider chain
    logic [DIV_W-1:0]          rem_w  [0:rbv_pkg::QUO_W];
    logic [rbv_pkg::QUO_W-1:0] quo_w  [0:rbv_pkg::QUO_W];
    rbv_pkg::flag_t            flg_w  [0:rbv_pkg::QUO_W];
    rbv_pkg::pix_t             pix_w  [0:rbv_pkg::QUO_W];

    // Output stage
    logic [rbv_pkg::CHAN_W-1:0] boost;
    logic [rbv_pkg::CHAN_W:0]   sum_b;
    logic [rbv_pkg::CHAN_W:0]   sum_g;
    logic [rbv_pkg::CHAN_W:0]   sum_r;
    rbv_pkg::pix_t              out_next;
    rbv_pkg::pix_t              out_reg;

    rbv_bound #(
        .MAX_DIM (MAX_DIM),
        .BOUND_W (BOUND_W)
    ) u_bound (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .center_x  (center_x),
        .center_y  (center_y),
        .bound     (bound)
    );

    // Stage enables: a stage loads when empty or when its successor loads
    assign en[LAST] = !v_reg[LAST] || m_tready;
    for (genvar i = 0; i < LAST; i++) begin : g_en
        assign en[i] = !v_reg[i] || en[i+1];
    end

    assign v_next = {v_reg[NST-2:0], s_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            for (int i = 0; i < NST; i++) begin
                if (en[i]) begin
                    v_reg[i] <= v_next[i];
                end
            end
        end
    end

    // Unpack input
    assign pixel_row = s_tdata[11:0];
    assign pixel_col = s_tdata[23:12];
    assign pix_in.blue = s_tdata[31:24];
    assign pix_in.green = s_tdata[39:32];
    assign pix_in.red = s_tdata[47:40];

    // Stage 0: signed offsets from the center
    always_comb begin
        dx_next = $signed({center_x[rbv_pkg::CENTER_W-1], center_x})
                - $signed({3'b000, pixel_col});
        dy_next = $signed({center_y[rbv_pkg::CENTER_W-1], center_y})
                - $signed({3'b000, pixel_row});
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            dx_reg   <= dx_next;
            dy_reg   <= dy_next;
            pix0_reg <= pix_in;
        end
    end

    // Stage 1: squares
    assign sqx_full = dx_reg * dx_reg;
    assign sqy_full = dy_reg * dy_reg;

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            sqx_reg  <= sqx_full[rbv_pkg::SQ_W-1:0];
            sqy_reg  <= sqy_full[rbv_pkg::SQ_W-1:0];
            pix1_reg <= pix0_reg;
        end
    end

    // Stage 2: ra in Q.16 against bound and twice bound
    always_comb begin
        ra = rbv_pkg::RA_W'(sqx_reg) + rbv_pkg::RA_W'(sqy_reg);
        x_val = CW'({ra, {rbv_pkg::FRAC_W{1'b0}}});
        b_ext = CW'(bound);
        flg2_next.zero = (x_val <= b_ext);
        flg2_next.full = (x_val >= (b_ext << 1));
        x_diff = x_val - b_ext;
    end

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            d_reg    <= x_diff[BOUND_W-1:0];
            flg2_reg <= flg2_next;
            pix2_reg <= pix1_reg;
        end
    end

    // Stage 3: numerator
    always_ff @(posedge aclk) begin
        if (en[3]) begin
            num_reg  <= (DIV_W'(d_reg) << rbv_pkg::QUO_W) - DIV_W'(d_reg);
            flg3_reg <= flg2_reg;
            pix3_reg <= pix2_reg;
        end
    end

    // Divider: one quotient bit per stage, most significant first
    assign rem_w[0] = num_reg;
    assign quo_w[0] = '0;
    assign flg_w[0] = flg3_reg;
    assign pix_w[0] = pix3_reg;

    for (genvar j = 0; j < rbv_pkg::QUO_W; j++) begin : g_div
        rbv_div_step #(
            .BOUND_W (BOUND_W),
            .K       (rbv_pkg::QUO_W - 1 - j)
        ) u_step (
            .aclk     (aclk),
            .load     (en[DIV_FIRST + j]),
            .rem_in   (rem_w[j]),
            .quo_in   (quo_w[j]),
            .flag_in  (flg_w[j]),
            .pix_in   (pix_w[j]),
            .bound    (bound),
            .rem_out  (rem_w[j+1]),
            .quo_out  (quo_w[j+1]),
            .flag_out (flg_w[j+1]),
            .pix_out  (pix_w[j+1])
        );
    end

    // Output stage: pick the boost and saturate each channel
    always_comb begin
        if (flg_w[rbv_pkg::QUO_W].zero) begin
            boost = '0;
        end else if (flg_w[rbv_pkg::QUO_W].full) begin
            boost = rbv_pkg::CHAN_MAX;
        end else begin
            boost = quo_w[rbv_pkg::QUO_W];
        end
        sum_b = {1'b0, pix_w[rbv_pkg::QUO_W].blue} + {1'b0, boost};
        sum_g = {1'b0, pix_w[rbv_pkg::QUO_W].green} + {1'b0, boost};
        sum_r = {1'b0, pix_w[rbv_pkg::QUO_W].red} + {1'b0, boost};
        out_next.blue = sum_b[rbv_pkg::CHAN_W] ? rbv_pkg::CHAN_MAX : sum_b[rbv_pkg::CHAN_W-1:0];
        out_next.green = sum_g[rbv_pkg::CHAN_W] ? rbv_pkg::CHAN_MAX : sum_g[rbv_pkg::CHAN_W-1:0];
        out_next.red = sum_r[rbv_pkg::CHAN_W] ? rbv_pkg::CHAN_MAX : sum_r[rbv_pkg::CHAN_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en[LAST]) begin
            out_reg <= out_next;
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = v_reg[LAST];
    assign m_tdata = {out_reg.red, out_reg.green, out_reg.blue};

    // An accepted transfer lands in the first stage
    `RBV_ASSERT_NEXT(a_accept_lands, aclk, aresetn, s_tvalid && s_tready, v_reg[0])
    // Stage 1 never loads while stage 0 holds, so no item is copied twice
    `RBV_ASSERT_IMPLY(a_enable_chain, aclk, aresetn, en[1], en[0])
    // Between bound and twice bound the quotient stays below 255
    `RBV_ASSERT_IMPLY(a_quotient_range, aclk, aresetn,
        v_reg[LAST-1] && !flg_w[rbv_pkg::QUO_W].zero && !flg_w[rbv_pkg::QUO_W].full,
        quo_w[rbv_pkg::QUO_W] != rbv_pkg::CHAN_MAX)

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import rbv_pkg::*;

    localparam int LATENCY     = 13;
    localparam int SETTLE      = 4;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SHOW_MAX    = 10;
    localparam logic [IDX_W-1:0] IDX_TOP = '1;

    // Tracks register state, predicts each brightened pixel, and checks results in order
    class brighten_scoreboard;
        logic signed [CENTER_W-1:0] center_x;
        logic signed [CENTER_W-1:0] center_y;
        logic [LEVEL_W-1:0]         level;
        logic [DIMREG_W-1:0]        rows;
        logic [DIMREG_W-1:0]        cols;
        longint unsigned            bound_q16;
        pix_t                       expected_pixels[$];
        int                         errors;

        function new();
            center_x  = '0;
            center_y  = '0;
            level     = '0;
            rows      = DIMREG_W'(1);
            cols      = DIMREG_W'(1);
            bound_q16 = 0;
            errors    = 0;
        endfunction

        function longint unsigned half_area(logic [DIMREG_W-1:0] n);
            longint unsigned d;
            d = (n > MAX_DIM_DEF) ? MAX_DIM_DEF : n;
            return ((d / 2) * d) / 2;
        endfunction

        // Update one register and recompute the Q.16 radius bound
        function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            longint unsigned lv;
            case (idx)
                REG_CENTER_X:   center_x = val[CENTER_W-1:0];
                REG_CENTER_Y:   center_y = val[CENTER_W-1:0];
                REG_LEVEL_Q16:  level    = val[LEVEL_W-1:0];
                REG_IMAGE_ROWS: rows     = val[DIMREG_W-1:0];
                REG_IMAGE_COLS: cols     = val[DIMREG_W-1:0];
                default:        return;
            endcase
            lv = (level > LEVEL_MAX_Q16) ? LEVEL_MAX_Q16 : level;
            bound_q16 = (longint'(ONE_Q16) - lv) * (half_area(rows) + half_area(cols));
        endfunction

        function logic [CHAN_W-1:0] sat_chan(logic [CHAN_W-1:0] c, longint unsigned boost);
            longint unsigned s;
            s = c + boost;
            return (s > CHAN_MAX) ? CHAN_MAX : s[CHAN_W-1:0];
        endfunction

        // Boost grows with squared distance past the bound, then saturates per channel
        function pix_t brighten_pixel(logic [47:0] d);
            longint          dx;
            longint          dy;
            longint unsigned ra;
            longint unsigned ra_q16;
            longint unsigned boost;
            pix_t            p;
            dx = center_x;
            dy = center_y;
            dx = dx - longint'(d[23:12]);
            dy = dy - longint'(d[11:0]);
            ra = dx * dx + dy * dy;
            if (bound_q16 == 0) begin
                boost = (ra > 0) ? CHAN_MAX : 0;
            end else begin
                ra_q16 = ra << FRAC_W;
                if (ra_q16 > bound_q16) begin
                    boost = ((ra_q16 - bound_q16) * CHAN_MAX) / bound_q16;
                    if (boost > CHAN_MAX)
                        boost = CHAN_MAX;
                end else begin
                    boost = 0;
                end
            end
            p.blue  = sat_chan(d[31:24], boost);
            p.green = sat_chan(d[39:32], boost);
            p.red   = sat_chan(d[47:40], boost);
            return p;
        endfunction

        function void note_pixel(logic [47:0] d);
            expected_pixels = {expected_pixels, brighten_pixel(d)};
        endfunction

        // Compare one output transfer against the oldest prediction
        function void check_pixel(logic [23:0] d);
            pix_t want;
            if (expected_pixels.size() == 0) begin
                errors++;
                if (errors <= SHOW_MAX)
                    $display("unexpected output transfer: %h", d);
                return;
            end
            want = expected_pixels.pop_front();
            if (want.blue != d[7:0] || want.green != d[15:8] || want.red != d[23:16]) begin
                errors++;
                if (errors <= SHOW_MAX)
                    $display("pixel mismatch: expected b=%0d g=%0d r=%0d, got b=%0d g=%0d r=%0d",
                             want.blue, want.green, want.red, d[7:0], d[15:8], d[23:16]);
            end
        endfunction
    endclass

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [IDX_W-1:0]     cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [47:0]          s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [23:0]          m_tdata;

    int                   tx_idle_pct = 13;
    int                   rx_idle_pct = 78;
    int                   cycles      = 0;
    brighten_scoreboard   brighten_sb = new();

    radial_brighten_vignette_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Stall the output side at random and check every output transfer
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99, 0) >= rx_idle_pct);
        if (aresetn && m_tvalid && m_tready)
            brighten_sb.check_pixel(m_tdata);
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic [47:0] pack_pixel(logic [11:0] row, logic [11:0] col,
                                               logic [7:0] b, logic [7:0] g, logic [7:0] r);
        return {r, g, b, col, row};
    endfunction

    // Insert random gaps, then hold the pixel until the transfer completes
    task automatic send_pixel(input logic [47:0] d);
        while ($urandom_range(99, 0) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        brighten_sb.note_pixel(d);
    endtask

    // Drain the pipeline, then load all registers plus a write to an unused index
    task automatic apply_regs(input logic [CFG_W-1:0] cx, input logic [CFG_W-1:0] cy,
                              input logic [CFG_W-1:0] lv, input logic [CFG_W-1:0] nrows,
                              input logic [CFG_W-1:0] ncols);
        logic [IDX_W-1:0] idx [6];
        logic [CFG_W-1:0] val [6];
        s_tvalid <= 1'b0;
        while (brighten_sb.expected_pixels.size() != 0)
            @(posedge aclk);
        repeat (LATENCY) @(posedge aclk);
        idx[0] = IDX_W'($urandom_range(IDX_TOP, REG_IMAGE_COLS + 1));
        val[0] = CFG_W'($urandom);
        idx[1] = REG_CENTER_X;   val[1] = cx;
        idx[2] = REG_CENTER_Y;   val[2] = cy;
        idx[3] = REG_LEVEL_Q16;  val[3] = lv;
        idx[4] = REG_IMAGE_ROWS; val[4] = nrows;
        idx[5] = REG_IMAGE_COLS; val[5] = ncols;
        for (int i = 0; i < 6; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            brighten_sb.write_reg(idx[i], val[i]);
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
        // let the radius bound settle
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Mostly small images so the boost spans its range; some empty or oversized
    function automatic logic [CFG_W-1:0] pick_dim();
        int sel;
        sel = $urandom_range(99, 0);
        if (sel < 60)
            return CFG_W'($urandom_range(128, 1));
        if (sel < 75)
            return CFG_W'($urandom_range(MAX_DIM_DEF, 129));
        if (sel < 80)
            return '0;
        if (sel < 85)
            return CFG_W'(MAX_DIM_DEF);
        return CFG_W'($urandom);
    endfunction

    function automatic int dim_limit(logic [DIMREG_W-1:0] dim);
        if (dim == 0)
            return 0;
        return (dim > MAX_DIM_DEF) ? MAX_DIM_DEF - 1 : dim - 1;
    endfunction

    function automatic logic [CFG_W-1:0] pick_center(logic [CFG_W-1:0] dim);
        if ($urandom_range(99, 0) < 75)
            return CFG_W'($urandom_range(dim_limit(dim[DIMREG_W-1:0]) + 1, 0));
        return CFG_W'($urandom);
    endfunction

    function automatic logic [11:0] pick_coord(logic [DIMREG_W-1:0] dim);
        if ($urandom_range(99, 0) < 80)
            return 12'($urandom_range(dim_limit(dim), 0));
        return 12'($urandom);
    endfunction

    function automatic logic [7:0] pick_chan();
        int sel;
        sel = $urandom_range(9, 0);
        if (sel == 0)
            return 8'd0;
        if (sel == 1)
            return 8'd255;
        return 8'($urandom);
    endfunction

    task automatic random_settings();
        logic [CFG_W-1:0] nrows;
        logic [CFG_W-1:0] ncols;
        logic [CFG_W-1:0] lv;
        int               sel;
        nrows = pick_dim();
        ncols = pick_dim();
        sel   = $urandom_range(99, 0);
        if (sel < 15)
            lv = '0;
        else if (sel < 25)
            lv = LEVEL_MAX_Q16;
        else if (sel < 30)
            lv = LEVEL_MAX_Q16 + 16'd1;
        else if (sel < 35)
            lv = '1;
        else
            lv = CFG_W'($urandom);
        apply_regs(pick_center(ncols), pick_center(nrows), lv, nrows, ncols);
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset defaults: zero bound, so any nonzero distance saturates the boost
        send_pixel(pack_pixel(12'd0, 12'd0, 8'd0, 8'd0, 8'd0));
        send_pixel(pack_pixel(12'd0, 12'd0, 8'd255, 8'd255, 8'd255));
        send_pixel(pack_pixel(12'd0, 12'd0, 8'h12, 8'h34, 8'h56));
        send_pixel(pack_pixel(12'd1, 12'd0, 8'd0, 8'd1, 8'd254));
        send_pixel(pack_pixel(12'hfff, 12'hfff, 8'd0, 8'h80, 8'hff));

        // Extreme centers with stray bits, level above the clamp, oversized and zero dims
        apply_regs(16'hdfff, 16'h6000, 16'hffff, 16'hffff, 16'h0000);
        send_pixel(pack_pixel(12'd0, 12'd0, 8'd0, 8'd0, 8'd0));
        send_pixel(pack_pixel(12'hfff, 12'hfff, 8'd255, 8'd0, 8'd7));
        send_pixel(pack_pixel(12'h800, 12'h800, pick_chan(), pick_chan(), pick_chan()));
        send_pixel(pack_pixel(12'h555, 12'haaa, pick_chan(), pick_chan(), pick_chan()));

        // Half level on a 16x16 image: tie at the bound, partial and full boost
        apply_regs(16'd0, 16'd0, 16'd32768, 16'd16, 16'd16);
        send_pixel(pack_pixel(12'd0, 12'd8, 8'd10, 8'd20, 8'd30));
        send_pixel(pack_pixel(12'd6, 12'd6, 8'd10, 8'd200, 8'd240));
        send_pixel(pack_pixel(12'd8, 12'd8, 8'd0, 8'd0, 8'd0));
        send_pixel(pack_pixel(12'd15, 12'd15, 8'd1, 8'd2, 8'd3));
        send_pixel(pack_pixel(12'd5, 12'd6, 8'd100, 8'd100, 8'd100));

        // Level exactly at the clamp on a full-size image
        apply_regs(16'd2048, 16'd2048, LEVEL_MAX_Q16, CFG_W'(MAX_DIM_DEF),
                   CFG_W'(MAX_DIM_DEF));
        send_pixel(pack_pixel(12'd2048, 12'd2048, 8'd9, 8'd9, 8'd9));
        send_pixel(pack_pixel(12'd0, 12'd0, 8'd9, 8'd9, 8'd9));
        send_pixel(pack_pixel(12'hfff, 12'hfff, 8'd200, 8'd100, 8'd50));
        send_pixel(pack_pixel(12'd1500, 12'd2600, pick_chan(), pick_chan(), pick_chan()));

        // Level zero: bound at its widest
        apply_regs(16'd0, 16'd0, 16'd0, CFG_W'(MAX_DIM_DEF), CFG_W'(MAX_DIM_DEF));
        send_pixel(pack_pixel(12'd2048, 12'd2048, 8'd50, 8'd60, 8'd70));
        send_pixel(pack_pixel(12'hfff, 12'hfff, 8'd50, 8'd60, 8'd70));
        send_pixel(pack_pixel(12'hfff, 12'd0, 8'd0, 8'd255, 8'd128));

        // Random settings and pixels under each idling mix
        for (int phase = 0; phase < 3; phase++) begin
            tx_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 78 : 0;
            rx_idle_pct = (phase == 0) ? 78 : (phase == 1) ? 13 : 0;
            for (int blk = 0; blk < 6; blk++) begin
                random_settings();
                for (int n = 0; n < 100; n++)
                    send_pixel(pack_pixel(pick_coord(brighten_sb.rows),
                                          pick_coord(brighten_sb.cols),
                                          pick_chan(), pick_chan(), pick_chan()));
            end
        end

        // Drain and finish
        s_tvalid <= 1'b0;
        while (brighten_sb.expected_pixels.size() != 0)
            @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
        if (brighten_sb.errors == 0 && brighten_sb.expected_pixels.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
